// ===== design/json_array_scalar_tokenizer_defines.svh =====
`ifndef JSON_ARRAY_SCALAR_TOKENIZER_DEFINES_SVH
`define JSON_ARRAY_SCALAR_TOKENIZER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define JAST_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define JAST_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/jast_pkg.sv =====
`timescale 1ns / 1ps
package jast_pkg;

  typedef enum logic [2:0] {
    M_OPEN    = 3'd0,
    M_ARRAY   = 3'd1,
    M_STRING  = 3'd2,
    M_NUMBER  = 3'd3,
    M_LITERAL = 3'd4,
    M_DONE    = 3'd5,
    M_VALUE   = 3'd6
  } mode_t;

  typedef enum logic [2:0] {
    P_SIGN  = 3'd0,
    P_ZERO  = 3'd1,
    P_INT   = 3'd2,
    P_DOT   = 3'd3,
    P_FRAC  = 3'd4,
    P_E     = 3'd5,
    P_ESIGN = 3'd6,
    P_EXP   = 3'd7
  } phase_t;

  localparam logic [2:0] KIND_STRING = 3'd0;
  localparam logic [2:0] KIND_INT    = 3'd1;
  localparam logic [2:0] KIND_FLOAT  = 3'd2;
  localparam logic [2:0] KIND_NULL   = 3'd3;
  localparam logic [2:0] KIND_BOOL   = 3'd4;
  localparam logic [2:0] KIND_CLOSE  = 3'd5;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_SYNTAX   = 2'd1;
  localparam logic [1:0] ST_OVERFLOW = 2'd2;

  localparam logic [1:0] LIT_NULL  = 2'd0;
  localparam logic [1:0] LIT_TRUE  = 2'd1;
  localparam logic [1:0] LIT_FALSE = 2'd2;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_LBRACK = 8'h5b;
  localparam logic [7:0] CH_RBRACK = 8'h5d;
  localparam logic [7:0] CH_COMMA  = 8'h2c;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5c;
  localparam logic [7:0] CH_MINUS  = 8'h2d;
  localparam logic [7:0] CH_PLUS   = 8'h2b;
  localparam logic [7:0] CH_DOT    = 8'h2e;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_LO_E   = 8'h65;
  localparam logic [7:0] CH_UP_E   = 8'h45;
  localparam logic [7:0] CH_LO_N   = 8'h6e;
  localparam logic [7:0] CH_LO_T   = 8'h74;
  localparam logic [7:0] CH_LO_F   = 8'h66;

  localparam int RES_DEPTH = 4;
  localparam int RES_PTR_W = 2;
  localparam int RES_CNT_W = 3;
  localparam int TDATA_W   = 40;

  // Packed so that token_kind lands in the lowest bits.
  typedef struct packed {
    logic [1:0]  status;
    logic        bool_value;
    logic [15:0] token_end;
    logic [15:0] token_start;
    logic [2:0]  token_kind;
  } tok_t;

  typedef struct packed {
    logic v0;
    logic v1;
    tok_t tok0;
    tok_t tok1;
  } push_t;

  typedef struct packed {
    logic err;
    logic done;
  } core_stat_t;

  function automatic logic is_ws(input logic [7:0] c);
    return c == 8'h20 || c == 8'h0c || c == 8'h0a || c == 8'h0d ||
           c == 8'h09 || c == 8'h0b;
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= CH_ZERO && c <= CH_NINE;
  endfunction

  function automatic logic [2:0] lit_len(input logic [1:0] k);
    case (k)
      LIT_NULL:  return 3'd4;
      LIT_TRUE:  return 3'd4;
      LIT_FALSE: return 3'd5;
      default:   return 3'd0;
    endcase
  endfunction

  function automatic logic [7:0] lit_char(input logic [1:0] k, input logic [2:0] i);
    logic [7:0] c;
    c = CH_NUL;
    case (k)
      LIT_NULL: begin
        case (i)
          3'd1:    c = 8'h75;
          3'd2:    c = 8'h6c;
          3'd3:    c = 8'h6c;
          default: c = CH_LO_N;
        endcase
      end
      LIT_TRUE: begin
        case (i)
          3'd1:    c = 8'h72;
          3'd2:    c = 8'h75;
          3'd3:    c = 8'h65;
          default: c = CH_LO_T;
        endcase
      end
      LIT_FALSE: begin
        case (i)
          3'd1:    c = 8'h61;
          3'd2:    c = 8'h6c;
          3'd3:    c = 8'h73;
          3'd4:    c = 8'h65;
          default: c = CH_LO_F;
        endcase
      end
      default: c = CH_NUL;
    endcase
    return c;
  endfunction

endpackage

// ===== design/jast_in_stage.sv =====
`timescale 1ns / 1ps
module jast_in_stage (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       s_valid,
  output logic       s_ready,
  input  logic [7:0] s_byte,
  input  logic       s_restart,
  output logic       m_valid,
  input  logic       m_take,
  output logic [7:0] m_byte,
  output logic       m_restart
);

  logic       v_r;
  logic       v_nxt;
  logic [7:0] byte_r;
  logic       restart_r;

  assign s_ready   = !v_r || m_take;
  assign m_valid   = v_r;
  assign m_byte    = byte_r;
  assign m_restart = restart_r;

  always_comb begin
    v_nxt = v_r;
    if (s_ready) begin
      v_nxt = s_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else begin
      v_r <= v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s_valid && s_ready) begin
      byte_r    <= s_byte;
      restart_r <= s_restart;
    end
  end

endmodule

// ===== design/jast_parse.sv =====
`timescale 1ns / 1ps
module jast_parse #(
  parameter int OFFSET_WIDTH = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 fire,
  input  logic [7:0]           c,
  input  logic                 restart,
  output jast_pkg::push_t      push,
  output jast_pkg::core_stat_t stat
);

  localparam logic [OFFSET_WIDTH-1:0] OFF_ONE = {{(OFFSET_WIDTH-1){1'b0}}, 1'b1};
  localparam logic [OFFSET_WIDTH-1:0] OFF_MAX = {OFFSET_WIDTH{1'b1}};

  jast_pkg::mode_t         mode_r, mode_nxt, cur_mode;
  logic [OFFSET_WIDTH-1:0] off_r, off_nxt, cur_off;
  logic [OFFSET_WIDTH-1:0] tb_r, tb_nxt, cur_tb;
  logic [OFFSET_WIDTH-1:0] ab_r, ab_nxt, cur_ab;
  logic                    esc_r, esc_nxt, cur_esc;
  logic                    cn_r, cn_nxt, cur_cn;
  jast_pkg::phase_t        ph_r, ph_nxt, cur_ph;
  logic                    fr_r, fr_nxt, cur_fr;
  logic [2:0]              li_r, li_nxt, cur_li;
  logic [1:0]              lk_r, lk_nxt, cur_lk;
  logic                    err_r, err_nxt, cur_err;

  logic                    do_fail;
  logic [1:0]              fail_st;
  logic                    do_tok;
  logic                    do_close;
  logic [2:0]              tok_kind;
  logic [OFFSET_WIDTH-1:0] tok_start;
  logic [OFFSET_WIDTH-1:0] tok_end;
  logic                    tok_bv;
  logic [OFFSET_WIDTH-1:0] off_p1;
  logic [2:0]              li_p1;
  jast_pkg::tok_t          err_tok, val_tok, close_tok;

  function automatic logic [15:0] to16(input logic [OFFSET_WIDTH-1:0] v);
    logic [31:0] w;
    w = 32'(v);
    return w[15:0];
  endfunction

  always_comb begin
    cur_mode = restart ? jast_pkg::M_OPEN : mode_r;
    cur_off  = restart ? '0 : off_r;
    cur_tb   = restart ? '0 : tb_r;
    cur_ab   = restart ? '0 : ab_r;
    cur_esc  = restart ? 1'b0 : esc_r;
    cur_cn   = restart ? 1'b0 : cn_r;
    cur_ph   = restart ? jast_pkg::P_SIGN : ph_r;
    cur_fr   = restart ? 1'b0 : fr_r;
    cur_li   = restart ? 3'd0 : li_r;
    cur_lk   = restart ? jast_pkg::LIT_NULL : lk_r;
    cur_err  = restart ? 1'b0 : err_r;
  end

  assign off_p1 = cur_off + OFF_ONE;
  assign li_p1  = cur_li + 3'd1;

  always_comb begin
    mode_nxt  = cur_mode;
    off_nxt   = cur_off;
    tb_nxt    = cur_tb;
    ab_nxt    = cur_ab;
    esc_nxt   = cur_esc;
    cn_nxt    = cur_cn;
    ph_nxt    = cur_ph;
    fr_nxt    = cur_fr;
    li_nxt    = cur_li;
    lk_nxt    = cur_lk;
    err_nxt   = cur_err;
    do_fail   = 1'b0;
    fail_st   = jast_pkg::ST_SYNTAX;
    do_tok    = 1'b0;
    do_close  = 1'b0;
    tok_kind  = jast_pkg::KIND_STRING;
    tok_start = cur_tb;
    tok_end   = cur_off;
    tok_bv    = 1'b0;

    if (cur_err || cur_mode == jast_pkg::M_DONE) begin
      mode_nxt = cur_mode;
    end else if (cur_off == OFF_MAX) begin
      do_fail = 1'b1;
      fail_st = jast_pkg::ST_OVERFLOW;
    end else begin
      off_nxt = off_p1;
      case (cur_mode)
        jast_pkg::M_OPEN: begin
          if (c == jast_pkg::CH_LBRACK) begin
            ab_nxt   = cur_off;
            cn_nxt   = 1'b0;
            mode_nxt = jast_pkg::M_ARRAY;
          end else if (!jast_pkg::is_ws(c)) begin
            do_fail = 1'b1;
          end
        end
        jast_pkg::M_ARRAY, jast_pkg::M_VALUE: begin
          if (jast_pkg::is_ws(c)) begin
            mode_nxt = cur_mode;
          end else if (c == jast_pkg::CH_RBRACK) begin
            if (cur_mode == jast_pkg::M_VALUE) begin
              do_fail = 1'b1;
            end else begin
              do_close = 1'b1;
            end
          end else if (c == jast_pkg::CH_COMMA) begin
            if (cur_mode == jast_pkg::M_VALUE || !cur_cn) begin
              do_fail = 1'b1;
            end else begin
              mode_nxt = jast_pkg::M_VALUE;
              cn_nxt   = 1'b0;
            end
          end else if (cur_mode == jast_pkg::M_ARRAY && cur_cn) begin
            do_fail = 1'b1;
          end else if (c == jast_pkg::CH_QUOTE) begin
            tb_nxt   = off_p1;
            esc_nxt  = 1'b0;
            mode_nxt = jast_pkg::M_STRING;
          end else if (c == jast_pkg::CH_MINUS || jast_pkg::is_digit(c)) begin
            tb_nxt   = cur_off;
            fr_nxt   = 1'b0;
            mode_nxt = jast_pkg::M_NUMBER;
            if (c == jast_pkg::CH_MINUS) begin
              ph_nxt = jast_pkg::P_SIGN;
            end else if (c == jast_pkg::CH_ZERO) begin
              ph_nxt = jast_pkg::P_ZERO;
            end else begin
              ph_nxt = jast_pkg::P_INT;
            end
          end else if (c == jast_pkg::CH_LO_N || c == jast_pkg::CH_LO_T ||
                       c == jast_pkg::CH_LO_F) begin
            tb_nxt   = cur_off;
            li_nxt   = 3'd1;
            mode_nxt = jast_pkg::M_LITERAL;
            if (c == jast_pkg::CH_LO_N) begin
              lk_nxt = jast_pkg::LIT_NULL;
            end else if (c == jast_pkg::CH_LO_T) begin
              lk_nxt = jast_pkg::LIT_TRUE;
            end else begin
              lk_nxt = jast_pkg::LIT_FALSE;
            end
          end else begin
            do_fail = 1'b1;
          end
        end
        jast_pkg::M_STRING: begin
          if (c == jast_pkg::CH_NUL) begin
            do_fail = 1'b1;
          end else if (cur_esc) begin
            esc_nxt = 1'b0;
          end else if (c == jast_pkg::CH_BSLASH) begin
            esc_nxt = 1'b1;
          end else if (c == jast_pkg::CH_QUOTE) begin
            do_tok   = 1'b1;
            tok_kind = jast_pkg::KIND_STRING;
            mode_nxt = jast_pkg::M_ARRAY;
            cn_nxt   = 1'b1;
          end
        end
        jast_pkg::M_NUMBER: begin
          if (jast_pkg::is_digit(c)) begin
            case (cur_ph)
              jast_pkg::P_SIGN: begin
                ph_nxt = (c == jast_pkg::CH_ZERO) ? jast_pkg::P_ZERO : jast_pkg::P_INT;
              end
              jast_pkg::P_ZERO: do_fail = 1'b1;
              jast_pkg::P_INT:  ph_nxt = jast_pkg::P_INT;
              jast_pkg::P_DOT, jast_pkg::P_FRAC: ph_nxt = jast_pkg::P_FRAC;
              default: ph_nxt = jast_pkg::P_EXP;
            endcase
          end else if (c == jast_pkg::CH_DOT) begin
            if (cur_ph == jast_pkg::P_ZERO || cur_ph == jast_pkg::P_INT) begin
              ph_nxt = jast_pkg::P_DOT;
              fr_nxt = 1'b1;
            end else begin
              do_fail = 1'b1;
            end
          end else if (c == jast_pkg::CH_LO_E || c == jast_pkg::CH_UP_E) begin
            if (cur_ph == jast_pkg::P_ZERO || cur_ph == jast_pkg::P_INT ||
                cur_ph == jast_pkg::P_FRAC) begin
              ph_nxt = jast_pkg::P_E;
            end else begin
              do_fail = 1'b1;
            end
          end else if (c == jast_pkg::CH_PLUS || c == jast_pkg::CH_MINUS) begin
            if (cur_ph == jast_pkg::P_E) begin
              ph_nxt = jast_pkg::P_ESIGN;
            end else begin
              do_fail = 1'b1;
            end
          end else if (jast_pkg::is_ws(c) || c == jast_pkg::CH_COMMA ||
                       c == jast_pkg::CH_RBRACK) begin
            if (cur_ph == jast_pkg::P_ZERO || cur_ph == jast_pkg::P_INT ||
                cur_ph == jast_pkg::P_FRAC || cur_ph == jast_pkg::P_EXP) begin
              do_tok   = 1'b1;
              tok_kind = cur_fr ? jast_pkg::KIND_FLOAT : jast_pkg::KIND_INT;
              ph_nxt   = jast_pkg::P_SIGN;
              fr_nxt   = 1'b0;
              if (c == jast_pkg::CH_RBRACK) begin
                do_close = 1'b1;
              end else if (c == jast_pkg::CH_COMMA) begin
                mode_nxt = jast_pkg::M_VALUE;
                cn_nxt   = 1'b0;
              end else begin
                mode_nxt = jast_pkg::M_ARRAY;
                cn_nxt   = 1'b1;
              end
            end else begin
              do_fail = 1'b1;
            end
          end else begin
            do_fail = 1'b1;
          end
        end
        jast_pkg::M_LITERAL: begin
          if ((cur_lk != jast_pkg::LIT_NULL && cur_lk != jast_pkg::LIT_TRUE &&
               cur_lk != jast_pkg::LIT_FALSE) || cur_li >= jast_pkg::lit_len(cur_lk) ||
              c != jast_pkg::lit_char(cur_lk, cur_li)) begin
            do_fail = 1'b1;
          end else if (li_p1 == jast_pkg::lit_len(cur_lk)) begin
            do_tok   = 1'b1;
            tok_kind = (cur_lk == jast_pkg::LIT_NULL) ? jast_pkg::KIND_NULL
                                                      : jast_pkg::KIND_BOOL;
            tok_end  = off_p1;
            tok_bv   = (cur_lk == jast_pkg::LIT_TRUE);
            mode_nxt = jast_pkg::M_ARRAY;
            cn_nxt   = 1'b1;
            li_nxt   = 3'd0;
          end else begin
            li_nxt = li_p1;
          end
        end
        default: do_fail = 1'b1;
      endcase
    end

    if (do_close) begin
      mode_nxt = jast_pkg::M_DONE;
    end
    if (do_fail) begin
      err_nxt = 1'b1;
    end
  end

  always_comb begin
    err_tok.token_kind    = jast_pkg::KIND_STRING;
    err_tok.token_start   = to16(cur_off);
    err_tok.token_end     = to16(cur_off);
    err_tok.bool_value    = 1'b0;
    err_tok.status        = fail_st;

    val_tok.token_kind    = tok_kind;
    val_tok.token_start   = to16(tok_start);
    val_tok.token_end     = to16(tok_end);
    val_tok.bool_value    = tok_bv;
    val_tok.status        = jast_pkg::ST_OK;

    close_tok.token_kind  = jast_pkg::KIND_CLOSE;
    close_tok.token_start = to16(cur_ab);
    close_tok.token_end   = to16(off_p1);
    close_tok.bool_value  = 1'b0;
    close_tok.status      = jast_pkg::ST_OK;

    push.v0   = 1'b0;
    push.v1   = 1'b0;
    push.tok0 = err_tok;
    push.tok1 = close_tok;
    if (do_fail) begin
      push.v0 = fire;
    end else if (do_tok) begin
      push.v0   = fire;
      push.tok0 = val_tok;
      push.v1   = fire && do_close;
    end else if (do_close) begin
      push.v0   = fire;
      push.tok0 = close_tok;
    end
  end

  assign stat.err  = err_r;
  assign stat.done = (mode_r == jast_pkg::M_DONE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= jast_pkg::M_OPEN;
      off_r  <= '0;
      tb_r   <= '0;
      ab_r   <= '0;
      esc_r  <= 1'b0;
      cn_r   <= 1'b0;
      ph_r   <= jast_pkg::P_SIGN;
      fr_r   <= 1'b0;
      li_r   <= 3'd0;
      lk_r   <= jast_pkg::LIT_NULL;
      err_r  <= 1'b0;
    end else if (fire) begin
      mode_r <= mode_nxt;
      off_r  <= off_nxt;
      tb_r   <= tb_nxt;
      ab_r   <= ab_nxt;
      esc_r  <= esc_nxt;
      cn_r   <= cn_nxt;
      ph_r   <= ph_nxt;
      fr_r   <= fr_nxt;
      li_r   <= li_nxt;
      lk_r   <= lk_nxt;
      err_r  <= err_nxt;
    end
  end

endmodule

// ===== design/jast_res_fifo.sv =====
`timescale 1ns / 1ps
module jast_res_fifo (
  input  logic            clk,
  input  logic            rst_n,
  input  jast_pkg::push_t push,
  output logic            room2,
  output logic            m_valid,
  input  logic            m_ready,
  output jast_pkg::tok_t  m_tok,
  output logic            m_last
);

  jast_pkg::tok_t                   tok_r [jast_pkg::RES_DEPTH];
  logic [jast_pkg::RES_DEPTH-1:0]   last_r;
  logic [jast_pkg::RES_PTR_W-1:0]   wr_r, wr_nxt, wr_p1;
  logic [jast_pkg::RES_PTR_W-1:0]   rd_r, rd_nxt;
  logic [jast_pkg::RES_CNT_W-1:0]   cnt_r, cnt_nxt;
  logic                             pop;
  logic [jast_pkg::RES_CNT_W-1:0]   n_push;

  assign room2   = cnt_r <= jast_pkg::RES_CNT_W'(jast_pkg::RES_DEPTH - 2);
  assign m_valid = cnt_r != '0;
  assign m_tok   = tok_r[rd_r];
  assign m_last  = last_r[rd_r];
  assign pop     = m_valid && m_ready;
  assign wr_p1   = wr_r + 1'b1;
  assign n_push  = jast_pkg::RES_CNT_W'(push.v0) + jast_pkg::RES_CNT_W'(push.v1);

  always_comb begin
    wr_nxt  = wr_r + n_push[jast_pkg::RES_PTR_W-1:0];
    rd_nxt  = pop ? rd_r + 1'b1 : rd_r;
    cnt_nxt = cnt_r + n_push - jast_pkg::RES_CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.v0) begin
      tok_r[wr_r]  <= push.tok0;
      last_r[wr_r] <= !push.v1;
    end
    if (push.v1) begin
      tok_r[wr_p1]  <= push.tok1;
      last_r[wr_p1] <= 1'b1;
    end
  end

endmodule

// ===== design/json_array_scalar_tokenizer.sv =====
`timescale 1ns / 1ps
// Channel   Dir  Beat contents                                  Handshake
// in_*      in   text byte, restart flag                        tvalid/tready
// out_*     out  kind, start, end, bool, status; tlast on last  tvalid/tready
//
// One text byte per clock while the result queue has room; a byte is held in the
// input stage register, then parsed, and its results are registered in the result queue before out_*.
// A closing bracket that ends a number yields two beats through the
// four-entry result queue; input stalls only when fewer than two slots are free.
// rst_n is synchronous, active low; in_tuser restarts parsing at that byte.
module json_array_scalar_tokenizer #(
  parameter int OFFSET_WIDTH = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [7:0]                    in_tdata,  // [7:0] text_byte
  input  logic                          in_tuser,  // [0] restart
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [jast_pkg::TDATA_W-1:0]  out_tdata, // [2:0] token_kind, [18:3] token_start,
                                                   // [34:19] token_end, [35] bool_value,
                                                   // [37:36] status, [39:38] zero
  output logic                          out_tlast
);

`include "json_array_scalar_tokenizer_defines.svh"

  logic                 core_valid;
  logic [7:0]           core_byte;
  logic                 core_restart;
  logic                 core_fire;
  logic                 room2;
  jast_pkg::push_t      push;
  jast_pkg::core_stat_t stat;
  jast_pkg::tok_t       head_tok;

  assign core_fire = core_valid && room2;

  jast_in_stage u_in (
    .clk       (clk),
    .rst_n     (rst_n),
    .s_valid   (in_tvalid),
    .s_ready   (in_tready),
    .s_byte    (in_tdata),
    .s_restart (in_tuser),
    .m_valid   (core_valid),
    .m_take    (core_fire),
    .m_byte    (core_byte),
    .m_restart (core_restart)
  );

  jast_parse #(
    .OFFSET_WIDTH (OFFSET_WIDTH)
  ) u_parse (
    .clk     (clk),
    .rst_n   (rst_n),
    .fire    (core_fire),
    .c       (core_byte),
    .restart (core_restart),
    .push    (push),
    .stat    (stat)
  );

  jast_res_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .room2   (room2),
    .m_valid (out_tvalid),
    .m_ready (out_tready),
    .m_tok   (head_tok),
    .m_last  (out_tlast)
  );

  assign out_tdata = {2'b00, head_tok};

  `JAST_ASSERT_NOW(a_latched_silent, core_fire && !core_restart && (stat.err || stat.done), !push.v0, "result after error or close without restart")
  `JAST_ASSERT_NOW(a_pair_is_close, push.v1, push.v0 && push.tok1.token_kind == jast_pkg::KIND_CLOSE && (push.tok0.token_kind == jast_pkg::KIND_INT || push.tok0.token_kind == jast_pkg::KIND_FLOAT), "second result is not a number followed by array close")
  `JAST_ASSERT_NEXT(a_hold_item, core_valid && !core_fire, core_valid && $stable(core_byte) && $stable(core_restart), "stalled byte lost in input stage")
  `JAST_ASSERT_NOW(a_no_push_stall, push.v0, core_fire, "result pushed without a parsed byte")

endmodule

// ===== verif/tb_json_array_scalar_tokenizer.sv =====
`timescale 1ns / 1ps
module tb_json_array_scalar_tokenizer;
  import jast_pkg::*;

  localparam int HOLD_CYCLES    = 80;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 20;
  localparam int RANDOM_BYTES   = 1900;
  localparam int QUIET_TAIL     = 300;
  localparam logic [7:0] SPACES [6] = '{8'h20, 8'h0c, 8'h0a, 8'h0d, 8'h09, 8'h0b};

  class token_scoreboard;
    mode_t       mode;
    phase_t      phase;
    logic [15:0] pos;
    logic [15:0] tok_begin;
    logic [15:0] arr_begin;
    logic [2:0]  lit_pos;
    logic [1:0]  lit_kind;
    bit          esc;
    bit          need_comma;
    bit          frac;
    bit          halted;
    string       lit_word [3];
    tok_t        run_toks [$];
    tok_t        tok_due [$];
    bit          tail_due [$];
    int          mismatches;

    function new();
      lit_word   = '{"null", "true", "false"};
      mismatches = 0;
      clear();
    endfunction

    function void clear();
      mode       = M_OPEN;
      phase      = P_SIGN;
      pos        = '0;
      tok_begin  = '0;
      arr_begin  = '0;
      lit_pos    = '0;
      lit_kind   = LIT_NULL;
      esc        = 1'b0;
      need_comma = 1'b0;
      frac       = 1'b0;
      halted     = 1'b0;
    endfunction

    function bit is_space(logic [7:0] c);
      foreach (SPACES[i]) if (c == SPACES[i]) return 1'b1;
      return 1'b0;
    endfunction

    function bit is_num_char(logic [7:0] c);
      return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    function void emit(logic [2:0] kind, logic [15:0] first_pos, logic [15:0] end_pos,
                       bit bv, logic [1:0] st);
      tok_t t;
      t.token_kind  = kind;
      t.token_start = first_pos;
      t.token_end   = end_pos;
      t.bool_value  = bv;
      t.status      = st;
      run_toks.push_back(t);
    endfunction

    function void fail_at(logic [1:0] st);
      halted = 1'b1;
      emit(KIND_STRING, pos, pos, 1'b0, st);
    endfunction

    function void close_list();
      mode = M_DONE;
      emit(KIND_CLOSE, arr_begin, pos + 16'd1, 1'b0, ST_OK);
    endfunction

    function void open_value(logic [7:0] c);
      if (c == CH_QUOTE) begin
        tok_begin = pos + 16'd1;
        esc       = 1'b0;
        mode      = M_STRING;
      end else if (c == CH_MINUS || is_num_char(c)) begin
        tok_begin = pos;
        frac      = 1'b0;
        if (c == CH_MINUS) phase = P_SIGN;
        else if (c == CH_ZERO) phase = P_ZERO;
        else phase = P_INT;
        mode = M_NUMBER;
      end else if (c == CH_LO_N || c == CH_LO_T || c == CH_LO_F) begin
        tok_begin = pos;
        if (c == CH_LO_N) lit_kind = LIT_NULL;
        else if (c == CH_LO_T) lit_kind = LIT_TRUE;
        else lit_kind = LIT_FALSE;
        lit_pos = 3'd1;
        mode    = M_LITERAL;
      end else begin
        fail_at(ST_SYNTAX);
      end
    endfunction

    function void number_byte(logic [7:0] c);
      if (is_num_char(c)) begin
        case (phase)
          P_SIGN: begin
            if (c == CH_ZERO) phase = P_ZERO;
            else phase = P_INT;
          end
          P_ZERO:        fail_at(ST_SYNTAX);
          P_INT:         phase = P_INT;
          P_DOT, P_FRAC: phase = P_FRAC;
          default:       phase = P_EXP;
        endcase
      end else if (c == CH_DOT) begin
        if (phase != P_ZERO && phase != P_INT) fail_at(ST_SYNTAX);
        else begin
          phase = P_DOT;
          frac  = 1'b1;
        end
      end else if (c == CH_LO_E || c == CH_UP_E) begin
        if (!(phase inside {P_ZERO, P_INT, P_FRAC})) fail_at(ST_SYNTAX);
        else phase = P_E;
      end else if (c == CH_PLUS || c == CH_MINUS) begin
        if (phase != P_E) fail_at(ST_SYNTAX);
        else phase = P_ESIGN;
      end else if (is_space(c) || c == CH_COMMA || c == CH_RBRACK) begin
        if (!(phase inside {P_ZERO, P_INT, P_FRAC, P_EXP})) fail_at(ST_SYNTAX);
        else begin
          emit(frac ? KIND_FLOAT : KIND_INT, tok_begin, pos, 1'b0, ST_OK);
          phase = P_SIGN;
          frac  = 1'b0;
          if (c == CH_RBRACK) close_list();
          else if (c == CH_COMMA) begin
            mode       = M_VALUE;
            need_comma = 1'b0;
          end else begin
            mode       = M_ARRAY;
            need_comma = 1'b1;
          end
        end
      end else begin
        fail_at(ST_SYNTAX);
      end
    endfunction

    function void literal_byte(logic [7:0] c);
      if (c != lit_word[lit_kind][lit_pos]) fail_at(ST_SYNTAX);
      else begin
        lit_pos = lit_pos + 3'd1;
        if (lit_pos == lit_word[lit_kind].len()) begin
          mode       = M_ARRAY;
          need_comma = 1'b1;
          lit_pos    = '0;
          emit(lit_kind == LIT_NULL ? KIND_NULL : KIND_BOOL, tok_begin, pos + 16'd1,
               lit_kind == LIT_TRUE, ST_OK);
        end
      end
    endfunction

    function void take_byte(logic [7:0] c, bit rs);
      run_toks.delete();
      if (rs) clear();
      if (halted || mode == M_DONE) return;
      if (pos == 16'hffff) begin
        fail_at(ST_OVERFLOW);
      end else begin
        case (mode)
          M_OPEN: begin
            if (c == CH_LBRACK) begin
              arr_begin  = pos;
              need_comma = 1'b0;
              mode       = M_ARRAY;
            end else if (!is_space(c)) begin
              fail_at(ST_SYNTAX);
            end
          end
          M_ARRAY, M_VALUE: begin
            if (!is_space(c)) begin
              if (c == CH_RBRACK) begin
                if (mode == M_VALUE) fail_at(ST_SYNTAX);
                else close_list();
              end else if (c == CH_COMMA) begin
                if (mode == M_VALUE || !need_comma) fail_at(ST_SYNTAX);
                else begin
                  mode       = M_VALUE;
                  need_comma = 1'b0;
                end
              end else if (mode == M_ARRAY && need_comma) begin
                fail_at(ST_SYNTAX);
              end else begin
                open_value(c);
              end
            end
          end
          M_STRING: begin
            if (c == CH_NUL) fail_at(ST_SYNTAX);
            else if (esc) esc = 1'b0;
            else if (c == CH_BSLASH) esc = 1'b1;
            else if (c == CH_QUOTE) begin
              emit(KIND_STRING, tok_begin, pos, 1'b0, ST_OK);
              mode       = M_ARRAY;
              need_comma = 1'b1;
            end
          end
          M_NUMBER:  number_byte(c);
          M_LITERAL: literal_byte(c);
          default:   fail_at(ST_SYNTAX);
        endcase
        pos = pos + 16'd1;
      end
      foreach (run_toks[i]) begin
        tok_due.push_back(run_toks[i]);
        tail_due.push_back(i == run_toks.size() - 1);
      end
    endfunction

    task report_mismatch(string field, longint unsigned got, longint unsigned want);
      if (mismatches < 100)
        $display("token mismatch on %s: got 0x%0h, expected 0x%0h", field, got, want);
      mismatches++;
    endtask

    task check_token(logic [TDATA_W-1:0] data, logic tail);
      tok_t got;
      tok_t want;
      bit   want_tail;
      got = tok_t'(data[$bits(tok_t)-1:0]);
      if (tok_due.size() == 0) begin
        report_mismatch("unexpected beat", data, 0);
        return;
      end
      want      = tok_due.pop_front();
      want_tail = tail_due.pop_front();
      if (got.token_kind != want.token_kind)
        report_mismatch("token_kind", got.token_kind, want.token_kind);
      if (got.token_start != want.token_start)
        report_mismatch("token_start", got.token_start, want.token_start);
      if (got.token_end != want.token_end)
        report_mismatch("token_end", got.token_end, want.token_end);
      if (got.bool_value != want.bool_value)
        report_mismatch("bool_value", got.bool_value, want.bool_value);
      if (got.status != want.status)
        report_mismatch("status", got.status, want.status);
      if (tail !== want_tail)
        report_mismatch("tlast", tail, want_tail);
      if (data[TDATA_W-1:$bits(tok_t)] != '0)
        report_mismatch("pad bits", data[TDATA_W-1:$bits(tok_t)], 0);
    endtask
  endclass

  logic               clk        = 1'b0;
  logic               rst_n      = 1'b0;
  logic               in_tvalid  = 1'b0;
  logic               in_tready;
  logic [7:0]         in_tdata   = '0;
  logic               in_tuser   = 1'b0;
  logic               out_tvalid;
  logic               out_tready = 1'b0;
  logic [TDATA_W-1:0] out_tdata;
  logic               out_tlast;

  token_scoreboard sb;
  logic [7:0]      doc [$];
  int              sent;
  int              idle_cycles;
  int              hold_left;
  int              rx_gap;
  bit              hold_req;
  bit              idle_on;

  json_array_scalar_tokenizer DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  always #1 clk = ~clk;

  always @(negedge clk) begin
    if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left--;
    end else if (rx_gap > 0) begin
      out_tready <= 1'b0;
      rx_gap--;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      out_tready <= 1'b0;
      rx_gap = $urandom_range(0, 3);
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_token(out_tdata, out_tlast);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  task automatic send_byte(input logic [7:0] c, input bit rs);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= c;
    in_tuser  <= rs;
    do @(posedge clk); while (!in_tready);
    sb.take_byte(c, rs);
    sent++;
    @(negedge clk);
  endtask

  task automatic send_doc();
    foreach (doc[i]) send_byte(doc[i], i == 0);
  endtask

  function automatic void add_text(string s);
    for (int i = 0; i < s.len(); i++) doc.push_back(s[i]);
  endfunction

  task automatic send_text(string s);
    doc.delete();
    add_text(s);
    send_doc();
  endtask

  function automatic void add_space();
    if ($urandom_range(0, 1)) repeat ($urandom_range(1, 3))
      doc.push_back(SPACES[$urandom_range(0, 5)]);
  endfunction

  function automatic void add_digit();
    doc.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
  endfunction

  function automatic logic [7:0] plain_char();
    logic [7:0] c;
    do c = 8'($urandom_range(1, 255)); while (c == CH_QUOTE || c == CH_BSLASH);
    return c;
  endfunction

  function automatic void add_number();
    if ($urandom_range(0, 1)) doc.push_back(CH_MINUS);
    if ($urandom_range(0, 3) == 0) doc.push_back(CH_ZERO);
    else begin
      doc.push_back(CH_ZERO + 8'($urandom_range(1, 9)));
      repeat ($urandom_range(0, 3)) add_digit();
    end
    if ($urandom_range(0, 2) == 0) begin
      doc.push_back(CH_DOT);
      repeat ($urandom_range(1, 3)) add_digit();
    end
    if ($urandom_range(0, 3) == 0) begin
      doc.push_back($urandom_range(0, 1) ? CH_LO_E : CH_UP_E);
      case ($urandom_range(0, 2))
        0:       doc.push_back(CH_PLUS);
        1:       doc.push_back(CH_MINUS);
        default: ;
      endcase
      repeat ($urandom_range(1, 2)) add_digit();
    end
  endfunction

  function automatic void add_value();
    case ($urandom_range(0, 5))
      0, 1: begin
        doc.push_back(CH_QUOTE);
        repeat ($urandom_range(0, 5)) begin
          if ($urandom_range(0, 4) == 0) begin
            doc.push_back(CH_BSLASH);
            doc.push_back(8'($urandom_range(1, 255)));
          end else begin
            doc.push_back(plain_char());
          end
        end
        doc.push_back(CH_QUOTE);
      end
      2, 3:    add_number();
      4:       add_text("null");
      default: begin
        if ($urandom_range(0, 1)) add_text("true");
        else add_text("false");
      end
    endcase
  endfunction

  function automatic void build_doc();
    int pick;
    int at;
    pick = $urandom_range(0, 19);
    doc.delete();
    if (pick == 0) begin
      repeat ($urandom_range(1, 12)) doc.push_back(8'($urandom_range(0, 255)));
      return;
    end
    add_space();
    doc.push_back(CH_LBRACK);
    add_space();
    for (int i = 0; i < $urandom_range(0, 6); i++) begin
      if (i > 0) begin
        add_space();
        doc.push_back(CH_COMMA);
        add_space();
      end
      add_value();
    end
    add_space();
    doc.push_back(CH_RBRACK);
    if ($urandom_range(0, 3) == 0)
      repeat ($urandom_range(1, 3)) doc.push_back(8'($urandom_range(0, 255)));
    if (pick <= 4) begin
      at = $urandom_range(0, doc.size() - 1);
      case ($urandom_range(0, 2))
        0: doc[at] = 8'($urandom_range(0, 255));
        1: doc.insert(at, 8'($urandom_range(0, 255)));
        default: begin
          while (doc.size() > at) void'(doc.pop_back());
          doc.push_back(CH_NUL);
        end
      endcase
    end
  endfunction

  initial begin
    sb      = new();
    idle_on = 1'b1;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    doc.delete();
    doc.push_back(8'h0b);
    doc.push_back(8'h0c);
    add_text(" [\t");
    doc.push_back(8'h0d);
    add_text("\n\"a\\");
    doc.push_back(8'hff);
    add_text("\\\"\",-0.5E+3 ,10,null,true ,false,1e-2,7]x");
    send_doc();
    send_text("[]");
    send_text("[1 2");
    send_text("[,");
    send_text("[1,]");
    send_text("[01");
    send_text("{");
    send_text("[nul1");
    send_text("[1.e");
    send_text("[\"a\",,");
    send_text("[x5");
    doc.delete();
    add_text("[\"ab");
    doc.push_back(CH_NUL);
    send_doc();

    idle_on  = 1'b0;
    hold_req = 1'b1;
    doc.delete();
    doc.push_back(CH_LBRACK);
    repeat (30) add_text("7,");
    add_text("null]");
    send_doc();
    idle_on = 1'b1;

    while (sent < RANDOM_BYTES) begin
      if (sent > RANDOM_BYTES - QUIET_TAIL) idle_on = 1'b0;
      build_doc();
      send_doc();
    end
    in_tvalid <= 1'b0;
    idle_on = 1'b0;

    while (sb.tok_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.tok_due.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
